// ===== sv/u8t_pkg.sv =====
// u8t_pkg: shared types and constants of the 8N1 serial transceiver.
// Beat structs for both channels, receiver phase codes and register indexes.
// No dependencies.
`default_nettype none

package u8t_pkg;

   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_BIT_TICKS  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOPBACK_ENABLE = 4'd1;

   localparam logic [15:0] HALF_BIT_TICKS_RESET = 16'd217;

   localparam logic [3:0] DATA_BITS  = 4'd8;
   localparam logic [3:0] FRAME_BITS = 4'd10;
   localparam logic [9:0] FRAME_IDLE = 10'h3FF;

   typedef enum logic [1:0] {
      RX_IDLE = 2'd0,
      RX_DATA = 2'd1,
      RX_STOP = 2'd2
   } rx_phase_type;

   typedef struct packed {
      logic       line_in;
      logic       send_valid;
      logic [7:0] send_byte;
   } req_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] byte_value;
      logic       line_out;
      logic       receiving;
      logic       sending;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/u8t_step.sv =====
// u8t_step: receiver and transmitter state with the single-tick update logic.
// Advances one tick per beat; result reflects the state after the update.
// Depends on u8t_pkg.
`default_nettype none

module u8t_step (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire u8t_pkg::req_type req,
   input  wire logic [15:0]      half_bit_ticks,
   input  wire logic             loopback_enable,
   output u8t_pkg::rsp_type      rsp
);

   u8t_pkg::rx_phase_type rx_phase_ff, rx_phase_in;
   logic [17:0] rx_timer_ff, rx_timer_in, rx_timer_dec;
   logic [3:0]  rx_bit_count_ff, rx_bit_count_in;
   logic [7:0]  rx_shift_ff, rx_shift_in;
   logic [9:0]  tx_frame_ff, tx_frame_in;
   logic [3:0]  tx_bit_count_ff, tx_bit_count_in;
   logic [16:0] tx_timer_ff, tx_timer_in, tx_timer_dec;
   logic        tx_active_ff, tx_active_in;

   logic [15:0] half;
   logic [16:0] bit_ticks;
   logic [17:0] start_ticks;

   assign half        = (half_bit_ticks == 16'd0) ? 16'd1 : half_bit_ticks;
   assign bit_ticks   = {half, 1'b0};
   assign start_ticks = {2'b00, half} + {1'b0, bit_ticks};

   assign rx_timer_dec = (rx_timer_ff != 18'd0) ? rx_timer_ff - 18'd1 : rx_timer_ff;
   assign tx_timer_dec = (tx_timer_ff != 17'd0) ? tx_timer_ff - 17'd1 : tx_timer_ff;

   // receiver next state
   always_comb begin
      rx_phase_in     = rx_phase_ff;
      rx_timer_in     = rx_timer_ff;
      rx_bit_count_in = rx_bit_count_ff;
      rx_shift_in     = rx_shift_ff;
      unique case (rx_phase_ff)
         u8t_pkg::RX_DATA, u8t_pkg::RX_STOP: begin
            rx_timer_in = rx_timer_dec;
            if (rx_timer_dec == 18'd0) begin
               rx_timer_in = {1'b0, bit_ticks};
               if (rx_phase_ff == u8t_pkg::RX_DATA) begin
                  rx_shift_in     = {req.line_in, rx_shift_ff[7:1]};
                  rx_bit_count_in = rx_bit_count_ff + 4'd1;
                  if (rx_bit_count_in >= u8t_pkg::DATA_BITS) begin
                     rx_phase_in = u8t_pkg::RX_STOP;
                  end
               end else if (req.line_in) begin
                  rx_phase_in = u8t_pkg::RX_IDLE;
               end
            end
         end
         default: begin
            rx_phase_in = u8t_pkg::RX_IDLE;
            if (!req.line_in) begin
               rx_phase_in     = u8t_pkg::RX_DATA;
               rx_timer_in     = start_ticks;
               rx_bit_count_in = 4'd0;
            end
         end
      endcase
   end

   // transmitter next state
   always_comb begin
      tx_frame_in     = tx_frame_ff;
      tx_bit_count_in = tx_bit_count_ff;
      tx_timer_in     = tx_timer_ff;
      tx_active_in    = tx_active_ff;
      if (tx_active_ff) begin
         tx_timer_in = tx_timer_dec;
         if (tx_timer_dec == 17'd0) begin
            tx_frame_in     = {1'b1, tx_frame_ff[9:1]};
            tx_bit_count_in = tx_bit_count_ff + 4'd1;
            if (tx_bit_count_in >= u8t_pkg::FRAME_BITS) begin
               tx_active_in    = 1'b0;
               tx_frame_in     = u8t_pkg::FRAME_IDLE;
               tx_bit_count_in = 4'd0;
            end else begin
               tx_timer_in = bit_ticks;
            end
         end
      end else if (req.send_valid) begin
         tx_frame_in     = {1'b1, req.send_byte, 1'b0};
         tx_bit_count_in = 4'd0;
         tx_timer_in     = bit_ticks;
         tx_active_in    = 1'b1;
      end
   end

   // result of this tick
   always_comb begin
      rsp.byte_valid = (rx_phase_ff == u8t_pkg::RX_DATA) && (rx_phase_in == u8t_pkg::RX_STOP);
      rsp.byte_value = rsp.byte_valid ? rx_shift_in : 8'd0;
      rsp.receiving  = (rx_phase_in != u8t_pkg::RX_IDLE);
      rsp.sending    = tx_active_in;
      if (loopback_enable) begin
         rsp.line_out = req.line_in;
      end else begin
         rsp.line_out = tx_active_in ? tx_frame_in[0] : 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_phase_ff     <= u8t_pkg::RX_IDLE;
         rx_timer_ff     <= 18'd0;
         rx_bit_count_ff <= 4'd0;
         rx_shift_ff     <= 8'd0;
         tx_frame_ff     <= u8t_pkg::FRAME_IDLE;
         tx_bit_count_ff <= 4'd0;
         tx_timer_ff     <= 17'd0;
         tx_active_ff    <= 1'b0;
      end else if (step_en) begin
         rx_phase_ff     <= rx_phase_in;
         rx_timer_ff     <= rx_timer_in;
         rx_bit_count_ff <= rx_bit_count_in;
         rx_shift_ff     <= rx_shift_in;
         tx_frame_ff     <= tx_frame_in;
         tx_bit_count_ff <= tx_bit_count_in;
         tx_timer_ff     <= tx_timer_in;
         tx_active_ff    <= tx_active_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/uart_8n1_transceiver.sv =====
// uart_8n1_transceiver: 8N1 serial receiver and transmitter, one tick per beat.
// The response beat is registered in the output stage; throughput 1 beat per cycle while the output
// is not stalled, set by the single registered update pass in u8t_step and a two-entry output stage.
// Synchronous reset clears line state, the output stage and the registers to
// half_bit_ticks 217, loopback off. Depends on u8t_pkg and u8t_step.
`default_nettype none

module uart_8n1_transceiver (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire u8t_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output u8t_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [u8t_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [u8t_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [15:0] half_bit_ticks_ff;
   logic        loopback_enable_ff;

   logic             accept;
   logic             out_take;
   u8t_pkg::rsp_type step_rsp;

   logic             out_valid_ff;
   u8t_pkg::rsp_type out_data_ff;
   logic             skid_valid_ff;
   u8t_pkg::rsp_type skid_data_ff;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_bit_ticks_ff  <= u8t_pkg::HALF_BIT_TICKS_RESET;
         loopback_enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            u8t_pkg::CSR_HALF_BIT_TICKS:  half_bit_ticks_ff  <= csr_data;
            u8t_pkg::CSR_LOOPBACK_ENABLE: loopback_enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   u8t_step u_step (
      .clock           (clock),
      .reset           (reset),
      .step_en         (accept),
      .req             (req_data),
      .half_bit_ticks  (half_bit_ticks_ff),
      .loopback_enable (loopback_enable_ff),
      .rsp             (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !out_take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (accept) begin
         if (out_valid_ff && !out_take) begin
            skid_data_ff <= step_rsp;
         end else begin
            out_data_ff <= step_rsp;
         end
      end
   end

   // hold the skid beat only behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid beat without output beat");

   // a full skid entry can only come from a stalled output
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_stall))
      else $error("skid filled without stall");

   // a received byte leaves the receiver in its stop wait
   a_byte_receiving: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.byte_valid) |-> rsp_data.receiving)
      else $error("byte reported outside a frame");

   // drop the byte value outside a report
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.byte_valid) |-> (rsp_data.byte_value == 8'd0))
      else $error("byte value without report");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for the 8N1 serial transceiver, one line tick per beat.
// Drives framed and noisy line traffic plus send offers, predicts every response beat.
// Depends on u8t_pkg and uart_8n1_transceiver.
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned PHASE_TICKS = 100;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   u8t_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   u8t_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [u8t_pkg::CSR_INDEX_W-1:0] csr_index = u8t_pkg::CSR_HALF_BIT_TICKS;
   logic [u8t_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // line model state
   logic [15:0]           half_bit_m = u8t_pkg::HALF_BIT_TICKS_RESET;
   logic                  loopback_m = 1'b0;
   u8t_pkg::rx_phase_type rx_phase_m = u8t_pkg::RX_IDLE;
   logic [17:0]           rx_timer_m = '0;
   logic [3:0]            rx_bits_m = '0;
   logic [7:0]            rx_shift_m = '0;
   logic [9:0]            tx_frame_m = u8t_pkg::FRAME_IDLE;
   logic [3:0]            tx_bits_m = '0;
   logic [16:0]           tx_timer_m = '0;
   logic                  tx_busy_m = 1'b0;

   u8t_pkg::rsp_type due_ticks[$];
   u8t_pkg::rsp_type oldest_tick;
   int unsigned      mismatch_count = 0;
   int unsigned      tick_count = 0;
   int unsigned      burst_left = 0;
   int unsigned      quiet_cycles = 0;
   int unsigned      stall_window = 0;
   stall_mode_type   stall_mode = STALL_NONE;

   uart_8n1_transceiver u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   function automatic u8t_pkg::rsp_type serial_tick(input u8t_pkg::req_type beat);
      logic [17:0]      half;
      u8t_pkg::rsp_type r;
      half = (half_bit_m == 16'd0) ? 18'd1 : {2'b00, half_bit_m};
      r = '0;
      if (rx_phase_m == u8t_pkg::RX_DATA || rx_phase_m == u8t_pkg::RX_STOP) begin
         if (rx_timer_m != 0) rx_timer_m--;
         if (rx_timer_m == 0) begin
            rx_timer_m = half << 1;
            if (rx_phase_m == u8t_pkg::RX_DATA) begin
               rx_shift_m = {beat.line_in, rx_shift_m[7:1]};
               rx_bits_m++;
               if (rx_bits_m >= u8t_pkg::DATA_BITS) begin
                  r.byte_valid = 1'b1;
                  r.byte_value = rx_shift_m;
                  rx_phase_m = u8t_pkg::RX_STOP;
               end
            end else if (beat.line_in) begin
               rx_phase_m = u8t_pkg::RX_IDLE;
            end
         end
      end else begin
         rx_phase_m = u8t_pkg::RX_IDLE;
         if (!beat.line_in) begin
            rx_phase_m = u8t_pkg::RX_DATA;
            rx_timer_m = 18'(half * 3);
            rx_bits_m = '0;
         end
      end
      if (tx_busy_m) begin
         if (tx_timer_m != 0) tx_timer_m--;
         if (tx_timer_m == 0) begin
            tx_frame_m = {1'b1, tx_frame_m[9:1]};
            tx_bits_m++;
            if (tx_bits_m >= u8t_pkg::FRAME_BITS) begin
               tx_busy_m = 1'b0;
               tx_frame_m = u8t_pkg::FRAME_IDLE;
               tx_bits_m = '0;
            end else begin
               tx_timer_m = 17'(half << 1);
            end
         end
      end else if (beat.send_valid) begin
         tx_frame_m = {1'b1, beat.send_byte, 1'b0};
         tx_bits_m = '0;
         tx_timer_m = 17'(half << 1);
         tx_busy_m = 1'b1;
      end
      r.line_out = loopback_m ? beat.line_in : (tx_busy_m ? tx_frame_m[0] : 1'b1);
      r.receiving = (rx_phase_m != u8t_pkg::RX_IDLE);
      r.sending = tx_busy_m;
      return r;
   endfunction

   task automatic push_tick(input logic line, input logic offer, input logic [7:0] value);
      u8t_pkg::req_type beat;
      int unsigned      gap;
      beat.line_in = line;
      beat.send_valid = offer;
      beat.send_byte = value;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      due_ticks.push_back(serial_tick(beat));
      tick_count++;
   endtask

   // offer_one_in of 0 means no send offers
   task automatic hold_line(input logic level, input int unsigned n,
                            input int unsigned offer_one_in);
      logic offer;
      repeat (n) begin
         offer = (offer_one_in != 0) && ($urandom_range(1, offer_one_in) == 1);
         push_tick(level, offer, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_serial_byte(input logic [7:0] value, input int unsigned stop_low_bits,
                                   input int unsigned offer_one_in);
      int unsigned bit_ticks;
      int          i;
      bit_ticks = 2 * ((half_bit_m == 16'd0) ? 1 : int'(half_bit_m));
      hold_line(1'b0, bit_ticks, offer_one_in);
      for (i = 0; i < 8; i++) hold_line(value[i], bit_ticks, offer_one_in);
      hold_line(1'b0, stop_low_bits * bit_ticks, offer_one_in);
      hold_line(1'b1, bit_ticks * $urandom_range(1, 2), offer_one_in);
   endtask

   task automatic settle_line();
      while (rx_phase_m != u8t_pkg::RX_IDLE || tx_busy_m)
         push_tick(1'b1, 1'b0, 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (due_ticks.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [u8t_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [15:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == u8t_pkg::CSR_HALF_BIT_TICKS) half_bit_m = value;
      else if (idx == u8t_pkg::CSR_LOOPBACK_ENABLE) loopback_m = value[0];
   endtask

   task automatic test_idle_after_reset();
      push_tick(1'b1, 1'b0, 8'h00);
      push_tick(1'b1, 1'b0, 8'hFF);
   endtask

   // start tick on both sides, offer while busy, stop level held low
   task automatic test_zero_half_bit();
      write_reg(u8t_pkg::CSR_HALF_BIT_TICKS, 16'd0);
      write_reg(u8t_pkg::CSR_LOOPBACK_ENABLE, 16'd0);
      push_tick(1'b0, 1'b1, 8'hFF);
      push_tick(1'b0, 1'b1, 8'h00);
      hold_line(1'b0, 16, 0);
      hold_line(1'b0, 2, 0);
      hold_line(1'b1, 2, 0);
   endtask

   task automatic test_loopback();
      write_reg(u8t_pkg::CSR_LOOPBACK_ENABLE, 16'd1);
      push_tick(1'b1, 1'b1, 8'h81);
      push_tick(1'b0, 1'b0, 8'h7E);
      push_tick(1'b1, 1'b1, 8'h3C);
   endtask

   // wide timer reload, then a register change mid-frame
   task automatic test_wide_period();
      settle_line();
      write_reg(u8t_pkg::CSR_LOOPBACK_ENABLE, 16'd0);
      write_reg(u8t_pkg::CSR_HALF_BIT_TICKS, 16'hFFFF);
      hold_line(1'b1, 4, 0);
      write_reg(u8t_pkg::CSR_HALF_BIT_TICKS, 16'd300);
      push_tick(1'b0, 1'b1, 8'hC3);
      write_reg(u8t_pkg::CSR_HALF_BIT_TICKS, 16'd2);
      settle_line();
   endtask

   task automatic test_random_traffic();
      int unsigned phase_end;
      int unsigned offer_one_in;
      logic [7:0]  value;
      logic [15:0] half;
      repeat (8) begin
         case ($urandom_range(0, 7))
            0: half = 16'd0;
            1, 2, 3: half = 16'd1;
            4, 5: half = 16'd2;
            6: half = 16'd3;
            default: half = 16'($urandom_range(4, 6));
         endcase
         write_reg(u8t_pkg::CSR_HALF_BIT_TICKS, half);
         write_reg(u8t_pkg::CSR_LOOPBACK_ENABLE, 16'($urandom_range(0, 2) == 0));
         offer_one_in = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         phase_end = tick_count + PHASE_TICKS;
         while (tick_count < phase_end) begin
            case ($urandom_range(0, 9))
               0: value = 8'h00;
               1: value = 8'hFF;
               default: value = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 9))
               0: send_serial_byte(value, $urandom_range(1, 2), offer_one_in);
               1: repeat ($urandom_range(1, 8))
                     push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), value);
               2: hold_line(1'b1, $urandom_range(1, 12), offer_one_in);
               default: send_serial_byte(value, 0, offer_one_in);
            endcase
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_idle_after_reset();
      test_zero_half_bit();
      test_loopback();
      test_wide_period();
      test_random_traffic();
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && due_ticks.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      if (stall_window == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_window <= $urandom_range(16, 96);
      end else begin
         stall_window <= stall_window - 1;
      end
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   task automatic flag_beat(input string why, input u8t_pkg::rsp_type want,
                            input u8t_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch (%s) at %0t: want bv=%0b val=%02h out=%0b rx=%0b tx=%0b",
                  why, $realtime, want.byte_valid, want.byte_value, want.line_out,
                  want.receiving, want.sending);
         $display("   got bv=%0b val=%02h out=%0b rx=%0b tx=%0b",
                  got.byte_valid, got.byte_value, got.line_out, got.receiving,
                  got.sending);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_ticks.size() == 0) begin
            flag_beat("unexpected beat", '0, rsp_data);
         end else begin
            oldest_tick = due_ticks.pop_front();
            if (rsp_data.byte_valid !== oldest_tick.byte_valid ||
                rsp_data.byte_value !== oldest_tick.byte_value ||
                rsp_data.line_out !== oldest_tick.line_out ||
                rsp_data.receiving !== oldest_tick.receiving ||
                rsp_data.sending !== oldest_tick.sending)
               flag_beat("field", oldest_tick, rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
sv/u8t_pkg.sv
sv/u8t_step.sv
sv/uart_8n1_transceiver.sv
bench/tb_top.sv
